FILE: rtl/core/rcfd_pkg.sv
// ---------------------------------------------------------------------------
// rcfd_pkg: shared types and constants for the RC serial frame decoder
// Frame layout constants, CRC16 update, pulse scaling and the interfaces
// between the byte front end, the release queue and the channel back end.
// ---------------------------------------------------------------------------
`default_nettype none

package rcfd_pkg;

    // Frame layout
    localparam int          NUM_CHANNELS_DEF = 12;
    localparam int          WORD_SLOTS       = 12;
    localparam int          SLOT_W           = 4;
    localparam int          POS_W            = 5;
    localparam logic [7:0]  START_BYTE       = 8'hA1;
    localparam logic [15:0] CRC_POLY         = 16'h1021;

    // Pulse width scaling: raw * 1400 / 4096 + 800
    localparam int           PROD_W       = 27;
    localparam int           PULSE_W      = 15;
    localparam int           PULSE_SHIFT  = 12;
    localparam logic [10:0]  PULSE_SCALE  = 11'd1400;
    localparam logic [14:0]  PULSE_OFFSET = 15'd800;

    // Fixed reorder from frame position to output channel
    localparam logic [3:0] REMAP_TABLE [WORD_SLOTS] = '{
        4'd0, 4'd1, 4'd3, 4'd5, 4'd2, 4'd4, 4'd6, 4'd7, 4'd8, 4'd9, 4'd10, 4'd11
    };

    // Channel word write into the frame buffer
    typedef struct packed {
        logic              en;
        logic              bank;
        logic [SLOT_W-1:0] slot;
        logic [15:0]       data;
    } word_wr_t;

    // Buffer bank handed back once all its results have left
    typedef struct packed {
        logic en;
        logic bank;
    } bank_rel_t;

    // One byte through the CRC16 shift register, MSB first
    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/rcfd_front.sv
// ---------------------------------------------------------------------------
// rcfd_front: byte front end
// Tracks the frame position, runs the CRC, writes channel words into the
// current buffer bank and releases the bank to the back end on a CRC match.
// ---------------------------------------------------------------------------
`default_nettype none

module rcfd_front
    import rcfd_pkg::*;
#(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_rx_byte,
    output word_wr_t        word_wr,
    output logic            push_valid,
    output logic            push_bank,
    input  wire bank_rel_t  bank_rel
);

    localparam int             FRAME_BYTES = 2 * NUM_CHANNELS + 3;
    localparam logic [POS_W-1:0] CRC_HI_POS = POS_W'(FRAME_BYTES - 2);

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [15:0]      crc_reg, crc_next;
    logic [7:0]       pend_reg, pend_next;
    logic [7:0]       crc_hi_reg, crc_hi_next;
    logic             wr_bank_reg, wr_bank_next;
    logic [1:0]       busy_reg, busy_next;
    logic             accept;

    // Stall while the bank being filled still holds a released frame
    assign s_ready = ~busy_reg[wr_bank_reg];
    assign accept  = s_valid & s_ready;
    assign push_bank = wr_bank_reg;

    // Classify the byte by frame position and update state
    always_comb begin
        pos_next     = pos_reg;
        crc_next     = crc_reg;
        pend_next    = pend_reg;
        crc_hi_next  = crc_hi_reg;
        wr_bank_next = wr_bank_reg;
        push_valid   = 1'b0;
        word_wr      = '0;
        if (accept) begin
            if (pos_reg == '0) begin
                // start byte; drop anything else
                if (s_rx_byte == START_BYTE) begin
                    crc_next = crc_feed(16'h0000, s_rx_byte);
                    pos_next = POS_W'(1);
                end
            end else if (pos_reg < CRC_HI_POS) begin
                crc_next = crc_feed(crc_reg, s_rx_byte);
                if (pos_reg[0]) begin
                    pend_next = s_rx_byte;
                end else begin
                    word_wr.en   = 1'b1;
                    word_wr.bank = wr_bank_reg;
                    word_wr.slot = SLOT_W'(pos_reg[POS_W-1:1]) - SLOT_W'(1);
                    word_wr.data = {pend_reg, s_rx_byte};
                end
                pos_next = pos_reg + POS_W'(1);
            end else if (pos_reg == CRC_HI_POS) begin
                crc_hi_next = s_rx_byte;
                pos_next    = pos_reg + POS_W'(1);
            end else begin
                // final byte: release the bank on a match, drop otherwise
                pos_next = '0;
                if ({crc_hi_reg, s_rx_byte} == crc_reg) begin
                    push_valid   = 1'b1;
                    wr_bank_next = ~wr_bank_reg;
                end
            end
        end
    end

    // Track which banks hold released frames
    always_comb begin
        busy_next = busy_reg;
        if (bank_rel.en) begin
            busy_next[bank_rel.bank] = 1'b0;
        end
        if (push_valid) begin
            busy_next[wr_bank_reg] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= '0;
            crc_reg     <= '0;
            pend_reg    <= '0;
            crc_hi_reg  <= '0;
            wr_bank_reg <= 1'b0;
            busy_reg    <= '0;
        end else begin
            pos_reg     <= pos_next;
            crc_reg     <= crc_next;
            pend_reg    <= pend_next;
            crc_hi_reg  <= crc_hi_next;
            wr_bank_reg <= wr_bank_next;
            busy_reg    <= busy_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/rcfd_queue.sv
// ---------------------------------------------------------------------------
// rcfd_queue: release queue
// Two-entry FIFO of released buffer banks between front and back end.
// ---------------------------------------------------------------------------
`default_nettype none

module rcfd_queue
    import rcfd_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic push_valid,
    input  wire logic push_bank,
    output logic      pop_valid,
    output logic      pop_bank,
    input  wire logic pop
);

    logic [1:0] entry_reg, entry_next;
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_pop;

    assign pop_valid = (count_reg != 2'd0);
    assign pop_bank  = entry_reg[rd_ptr_reg];
    assign do_pop    = pop & pop_valid;

    // Advance pointers and count
    always_comb begin
        entry_next  = entry_reg;
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push_valid) begin
            entry_next[wr_ptr_reg] = push_bank;
            wr_ptr_next            = ~wr_ptr_reg;
        end
        if (do_pop) begin
            rd_ptr_next = ~rd_ptr_reg;
        end
        case ({push_valid, do_pop})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_reg  <= '0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end else begin
            entry_reg  <= entry_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/rcfd_back.sv
// ---------------------------------------------------------------------------
// rcfd_back: channel back end
// Holds the two-bank frame buffer, walks a released bank channel by
// channel, scales each word to microseconds and presents the results.
// ---------------------------------------------------------------------------
`default_nettype none

module rcfd_back
    import rcfd_pkg::*;
#(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire word_wr_t             word_wr,
    input  wire logic                 pop_valid,
    input  wire logic                 pop_bank,
    output logic                      pop,
    output bank_rel_t                 bank_rel,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic [3:0]                m_channel_index,
    output logic [PULSE_W-1:0]        m_pulse_us,
    output logic                      m_last
);

    localparam int CH_W = $clog2(NUM_CHANNELS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_MUL,
        ST_FMT,
        ST_OUT
    } state_t;

    state_t             state_reg;
    logic               bank_reg;
    logic [CH_W-1:0]    ch_reg;
    logic [15:0]        rdata_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic               m_valid_reg;
    logic [3:0]         index_reg;
    logic [PULSE_W-1:0] pulse_reg;
    logic               last_reg;
    logic               ch_is_last;

    logic [15:0] mem [2][NUM_CHANNELS];

    assign ch_is_last = (ch_reg == CH_W'(NUM_CHANNELS - 1));
    assign pop        = (state_reg == ST_IDLE) && pop_valid;

    // Hand the bank back once its last word is taken
    assign bank_rel.en   = (state_reg == ST_OUT) && m_ready && last_reg;
    assign bank_rel.bank = bank_reg;

    assign m_valid         = m_valid_reg;
    assign m_channel_index = index_reg;
    assign m_pulse_us      = pulse_reg;
    assign m_last          = last_reg;

    // Frame buffer: write from the front end, registered read
    always_ff @(posedge aclk) begin
        if (word_wr.en) begin
            mem[word_wr.bank][word_wr.slot[CH_W-1:0]] <= word_wr.data;
        end
        if (state_reg == ST_READ) begin
            rdata_reg <= mem[bank_reg][ch_reg];
        end
    end

    // Scale the raw word
    always_ff @(posedge aclk) begin
        if (state_reg == ST_MUL) begin
            prod_reg <= PROD_W'(rdata_reg) * PROD_W'(PULSE_SCALE);
        end
    end

    // Sequence channels and hold the output word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            bank_reg    <= 1'b0;
            ch_reg      <= '0;
            m_valid_reg <= 1'b0;
            index_reg   <= '0;
            pulse_reg   <= '0;
            last_reg    <= 1'b0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (pop_valid) begin
                        bank_reg  <= pop_bank;
                        ch_reg    <= '0;
                        state_reg <= ST_READ;
                    end
                end
                ST_READ: begin
                    state_reg <= ST_MUL;
                end
                ST_MUL: begin
                    state_reg <= ST_FMT;
                end
                ST_FMT: begin
                    index_reg   <= REMAP_TABLE[SLOT_W'(ch_reg)];
                    pulse_reg   <= prod_reg[PROD_W-1:PULSE_SHIFT] + PULSE_OFFSET;
                    last_reg    <= ch_is_last;
                    m_valid_reg <= 1'b1;
                    state_reg   <= ST_OUT;
                end
                ST_OUT: begin
                    if (m_ready) begin
                        m_valid_reg <= 1'b0;
                        if (last_reg) begin
                            state_reg <= ST_IDLE;
                        end else begin
                            ch_reg    <= ch_reg + CH_W'(1);
                            state_reg <= ST_READ;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/rc_serial_frame_decoder_crc16_unit.sv
// ---------------------------------------------------------------------------
// rc_serial_frame_decoder_crc16_unit: RC receiver frame decoder, CRC16
// Decodes fixed-length frames (start byte 0xA1, big-endian channel words,
// big-endian CRC16 over all earlier bytes) into per-channel pulse widths.
// ---------------------------------------------------------------------------
// Input bytes are taken one per clock while s_ready is high. Channel words
// go into one of two frame buffer banks; when the final byte of a frame
// matches the CRC, that bank is queued and the next frame fills the other
// bank. The back end picks the bank up from the queue and then emits one
// word per channel in frame order, each result passing through buffer
// read, multiply, format and present; it moves on to the next channel only
// once m_ready takes the presented word. s_ready drops only while both
// banks hold frames whose results have not all been taken. Bad start
// bytes and frames with a CRC mismatch produce no output.
`default_nettype none

module rc_serial_frame_decoder_crc16_unit
    import rcfd_pkg::*;
#(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [7:0]         s_rx_byte,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [3:0]              m_channel_index,
    output logic [PULSE_W-1:0]      m_pulse_us,
    output logic                    m_last
);

    word_wr_t  word_wr;
    bank_rel_t bank_rel;
    logic      push_valid;
    logic      push_bank;
    logic      pop_valid;
    logic      pop_bank;
    logic      pop;

    rcfd_front #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_rx_byte  (s_rx_byte),
        .word_wr    (word_wr),
        .push_valid (push_valid),
        .push_bank  (push_bank),
        .bank_rel   (bank_rel)
    );

    rcfd_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_bank  (push_bank),
        .pop_valid  (pop_valid),
        .pop_bank   (pop_bank),
        .pop        (pop)
    );

    rcfd_back #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .word_wr         (word_wr),
        .pop_valid       (pop_valid),
        .pop_bank        (pop_bank),
        .pop             (pop),
        .bank_rel        (bank_rel),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_channel_index (m_channel_index),
        .m_pulse_us      (m_pulse_us),
        .m_last          (m_last)
    );

endmodule

`default_nettype wire

FILE: tb/sv/tb_rc_serial_frame_decoder_crc16_unit.sv
// ---------------------------------------------------------------------------
// tb_rc_serial_frame_decoder_crc16_unit: self-checking bench for the decoder
// Feeds receiver bytes (junk start bytes, good frames, frames with a CRC
// error, extreme channel words) through the input channel. A behavioral
// decoder predicts every channel word, which is checked field by field on
// the output channel. Both sides idle and stall at random.
// ---------------------------------------------------------------------------

module tb_rc_serial_frame_decoder_crc16_unit;
    import rcfd_pkg::*;

    localparam int NCH          = NUM_CHANNELS_DEF;
    localparam int FRAME_LEN    = 2 * NCH + 3;
    localparam int RANDOM_BYTES = 20;
    localparam int HOLD_CYCLES  = 1000;
    localparam int DRAIN_CYCLES = 64;
    localparam int MAX_PRINTS   = 40;
    localparam logic [15:0] STALL_PATTERN = 16'b1011_0011_0110_1101;

    typedef enum logic [1:0] {FLAW_NONE, FLAW_CRC, FLAW_DATA} flaw_t;
    typedef enum logic [1:0] {ROW_JUNK, ROW_FILL, ROW_MIXED} row_kind_t;
    typedef enum logic [1:0] {RX_FREE, RX_RANDOM, RX_PATTERN} rx_mode_t;

    // One directed step: a lone byte or a whole frame of channel words
    typedef struct packed {
        row_kind_t          kind;
        flaw_t              flaw;
        logic [15:0]        fill;
        logic               has_pulse;
        logic [PULSE_W-1:0] pulse;
    } plan_row_t;

    typedef struct packed {
        logic [3:0]         index;
        logic [PULSE_W-1:0] pulse;
        logic               last;
    } chan_result_t;

    logic               aclk;
    logic               aresetn   = 1'b0;
    logic               s_valid   = 1'b0;
    logic               s_ready;
    logic [7:0]         s_rx_byte = 8'h00;
    logic               m_valid;
    logic               m_ready   = 1'b0;
    logic [3:0]         m_channel_index;
    logic [PULSE_W-1:0] m_pulse_us;
    logic               m_last;

    // Decoder state mirrored by the predictor
    int          frame_pos = 0;
    logic [15:0] crc_acc   = 16'h0000;
    logic [7:0]  word_hi   = 8'h00;
    logic [7:0]  crc_hi    = 8'h00;
    logic [15:0] word_buf [NCH];

    chan_result_t pulses_due [$];
    logic [15:0]  frame_words [NCH];
    plan_row_t    plan [7];

    int       errors         = 0;
    int       pulse_override = -1;
    int       burst_left     = 1;
    int       frame_bytes    = 0;
    int       hold_seq       = 0;
    int       hold_seen      = 0;
    int       hold_left      = 0;
    int       rx_cycle       = 0;
    rx_mode_t rx_mode        = RX_FREE;

    rc_serial_frame_decoder_crc16_unit #(
        .NUM_CHANNELS(NCH)
    ) uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_rx_byte       (s_rx_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_channel_index (m_channel_index),
        .m_pulse_us      (m_pulse_us),
        .m_last          (m_last)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("[rc_serial_frame_decoder_crc16_unit] ERROR");
        $finish;
    end

    // CRC16, polynomial 0x1021, one data bit at a time, MSB first
    function automatic logic [15:0] crc16_next(input logic [15:0] acc, input logic [7:0] data);
        logic [15:0] c;
        logic        fb;
        c = acc;
        for (int k = 7; k >= 0; k--) begin
            fb = c[15] ^ data[k];
            c  = {c[14:0], 1'b0};
            if (fb) begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

    // raw * 1400 / 4096 + 800, floor
    function automatic logic [PULSE_W-1:0] pulse_width(input logic [15:0] raw);
        logic [31:0] prod;
        prod = {16'd0, raw} * 32'd1400;
        return PULSE_W'((prod >> 12) + 32'd800);
    endfunction

    // Advance the predicted decoder by one accepted byte
    task automatic decode_byte(input logic [7:0] b);
        chan_result_t r;
        if (frame_pos == 0) begin
            // drop anything but the start byte
            if (b == START_BYTE) begin
                crc_acc   = crc16_next(16'h0000, b);
                frame_pos = 1;
            end
        end else if (frame_pos < FRAME_LEN - 2) begin
            crc_acc = crc16_next(crc_acc, b);
            if (frame_pos % 2 == 1) begin
                word_hi = b;
            end else begin
                word_buf[(frame_pos - 2) / 2] = {word_hi, b};
            end
            frame_pos++;
        end else if (frame_pos == FRAME_LEN - 2) begin
            crc_hi = b;
            frame_pos++;
        end else begin
            // final byte: release every channel only on a CRC match
            frame_pos = 0;
            if ({crc_hi, b} == crc_acc) begin
                for (int ch = 0; ch < NCH; ch++) begin
                    r.index = REMAP_TABLE[ch];
                    r.pulse = pulse_width(word_buf[ch]);
                    if (pulse_override >= 0) begin
                        r.pulse = pulse_override[PULSE_W-1:0];
                    end
                    r.last = (ch == NCH - 1);
                    pulses_due.push_back(r);
                end
            end
        end
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        errors++;
        if (errors <= MAX_PRINTS) begin
            $display("mismatch: %s got %0d expected %0d at %0t", what, got, want, $realtime);
        end
    endtask

    task automatic check_result();
        chan_result_t want;
        if (pulses_due.size() == 0) begin
            report_mismatch("unexpected word, pulse_us", m_pulse_us, -1);
        end else begin
            want = pulses_due.pop_front();
            if (m_channel_index !== want.index) begin
                report_mismatch("channel_index", m_channel_index, want.index);
            end
            if (m_pulse_us !== want.pulse) begin
                report_mismatch("pulse_us", m_pulse_us, want.pulse);
            end
            if (m_last !== want.last) begin
                report_mismatch("last", m_last, want.last);
            end
        end
    endtask

    // Offer one byte, hold it until accepted, then maybe end the burst
    task automatic send_byte(input logic [7:0] b);
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        decode_byte(b);
        burst_left--;
        if (burst_left <= 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 12);
        end
    endtask

    // Build a frame from frame_words, optionally break it, and send it
    task automatic send_frame(input flaw_t flaw);
        logic [7:0]  fb [FRAME_LEN];
        logic [15:0] c;
        int          k;
        fb[0] = START_BYTE;
        for (int i = 0; i < NCH; i++) begin
            fb[1 + 2 * i] = frame_words[i][15:8];
            fb[2 + 2 * i] = frame_words[i][7:0];
        end
        c = 16'h0000;
        for (int i = 0; i < FRAME_LEN - 2; i++) begin
            c = crc16_next(c, fb[i]);
        end
        fb[FRAME_LEN - 2] = c[15:8];
        fb[FRAME_LEN - 1] = c[7:0];
        // a single flipped bit always breaks the CRC
        case (flaw)
            FLAW_CRC: begin
                k = FRAME_LEN - 2 + $urandom_range(0, 1);
                fb[k] = fb[k] ^ (8'd1 << $urandom_range(0, 7));
            end
            FLAW_DATA: begin
                k = $urandom_range(1, FRAME_LEN - 3);
                fb[k] = fb[k] ^ (8'd1 << $urandom_range(0, 7));
            end
            default: begin
            end
        endcase
        for (int i = 0; i < FRAME_LEN; i++) begin
            send_byte(fb[i]);
        end
    endtask

    task automatic random_words();
        for (int i = 0; i < NCH; i++) begin
            case ($urandom_range(0, 9))
                0:       frame_words[i] = 16'h0000;
                1:       frame_words[i] = 16'hFFFF;
                2:       frame_words[i] = {START_BYTE, 8'($urandom)};
                default: frame_words[i] = 16'($urandom);
            endcase
        end
    endtask

    // Drop the offer, then wait for every predicted word
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (pulses_due.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    // Receiver: check each word, then pick ready from hold, mode or pattern
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                check_result();
            end
            if (hold_seq != hold_seen) begin
                hold_seen <= hold_seq;
                hold_left <= HOLD_CYCLES;
                m_ready   <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                m_ready   <= 1'b0;
            end else begin
                if (rx_cycle % 64 == 0) begin
                    rx_mode <= rx_mode_t'($urandom_range(0, 2));
                end
                rx_cycle <= rx_cycle + 1;
                case (rx_mode)
                    RX_FREE:   m_ready <= 1'b1;
                    RX_RANDOM: m_ready <= ($urandom_range(0, 3) != 0);
                    default:   m_ready <= STALL_PATTERN[rx_cycle % 16];
                endcase
            end
        end
    end

    // Sender: directed table under a receiver hold, then random frames and noise
    initial begin
        int        pick;
        logic [7:0] noise;
        plan = '{
            '{ROW_JUNK,  FLAW_NONE, 16'h0000, 1'b0, 15'd0},
            '{ROW_JUNK,  FLAW_NONE, 16'h00A0, 1'b0, 15'd0},
            '{ROW_FILL,  FLAW_NONE, 16'h0000, 1'b1, 15'd800},
            '{ROW_FILL,  FLAW_NONE, 16'hFFFF, 1'b1, 15'd23199},
            '{ROW_FILL,  FLAW_CRC,  16'h1234, 1'b0, 15'd0},
            '{ROW_FILL,  FLAW_DATA, 16'h5A5A, 1'b0, 15'd0},
            '{ROW_MIXED, FLAW_NONE, 16'hA1A1, 1'b0, 15'd0}
        };
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // hold the receiver off so the first frames fill both banks
        hold_seq <= hold_seq + 1;

        // directed rows; typed pulse widths replace the predicted ones
        foreach (plan[r]) begin
            pulse_override = plan[r].has_pulse ? int'(plan[r].pulse) : -1;
            case (plan[r].kind)
                ROW_JUNK: begin
                    send_byte(plan[r].fill[7:0]);
                end
                ROW_FILL: begin
                    foreach (frame_words[i]) frame_words[i] = plan[r].fill;
                    send_frame(plan[r].flaw);
                end
                default: begin
                    foreach (frame_words[i]) frame_words[i] = plan[r].fill ^ (16'(i) * 16'h1111);
                    send_frame(plan[r].flaw);
                end
            endcase
        end
        pulse_override = -1;
        wait_drained();

        // random mix: mostly good frames, some broken ones, some junk
        while (frame_bytes < RANDOM_BYTES) begin
            pick = $urandom_range(0, 99);
            if (pick < 10) begin
                repeat ($urandom_range(1, 5)) begin
                    noise = 8'($urandom);
                    if (noise == START_BYTE) begin
                        noise = noise ^ (8'd1 << $urandom_range(0, 7));
                    end
                    send_byte(noise);
                end
            end else begin
                random_words();
                if (pick < 25) begin
                    send_frame(($urandom_range(0, 1) == 0) ? FLAW_CRC : FLAW_DATA);
                end else begin
                    send_frame(FLAW_NONE);
                end
                frame_bytes += FRAME_LEN;
            end
        end
        if (s_valid) begin
            s_valid <= 1'b0;
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (errors == 0) begin
            $display("[rc_serial_frame_decoder_crc16_unit] OK");
        end else begin
            $display("[rc_serial_frame_decoder_crc16_unit] ERROR");
        end
        $finish;
    end

endmodule
